### sv/sdspi_pkg.sv
package sdspi_pkg;

    // Default largest block payload in bytes.
    localparam int MAX_BLOCK_LEN_DEF = 512;

    // Field widths.
    localparam int CMD_W    = 6;
    localparam int ARG_W    = 32;
    localparam int KIND_W   = 3;
    localparam int LEN_W    = 10;
    localparam int BYTE_W   = 8;
    localparam int RETRY_W  = 16;
    localparam int STATUS_W = 3;

    // Stream word widths (fields padded up to whole bytes).
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 64;

    // Configuration port.
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_BLOCK_ADDR  = 2'd0;
    localparam logic [1:0] REG_READY_LIM   = 2'd1;
    localparam logic [1:0] REG_RESP_LIM    = 2'd2;
    localparam logic [1:0] REG_START_LIM   = 2'd3;

    localparam logic                 BLOCK_ADDR_RST = 1'b0;
    localparam logic [RETRY_W-1:0]   READY_LIM_RST  = 16'd10000;
    localparam logic [BYTE_W-1:0]    RESP_LIM_RST   = 8'd100;
    localparam logic [RETRY_W-1:0]   START_LIM_RST  = 16'd2500;

    // Input operation codes.
    localparam logic OP_START    = 1'b0;
    localparam logic OP_EXCHANGE = 1'b1;

    // Transfer kinds.
    localparam logic [KIND_W-1:0] KIND_R1    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_R2    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_R3    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_READ  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_WRITE = 3'd4;

    // Completion status codes.
    localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] ST_READY_TMO    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RESP_TMO     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_R1_ERROR     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_START_TMO    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DATA_ERROR   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_WRITE_REJECT = 3'd6;

    // Bus byte values.
    localparam logic [BYTE_W-1:0] BYTE_IDLE      = 8'hFF;
    localparam logic [BYTE_W-1:0] BYTE_TOKEN     = 8'hFE;
    localparam logic [BYTE_W-1:0] BYTE_TIMEOUT   = 8'h80;
    localparam logic [BYTE_W-1:0] CRC_CMD8       = 8'h87;
    localparam logic [BYTE_W-1:0] CRC_OTHER      = 8'h95;
    localparam logic [BYTE_W-1:0] ERR_TOKEN_MASK = 8'hE0;
    localparam logic [4:0]        DRESP_ACCEPTED = 5'h05;
    localparam logic [CMD_W-1:0]  CMD_IF_COND    = 6'd8;

    // Last byte position sent for a command (its trailing idle byte), then byte counts.
    localparam logic [LEN_W-1:0] FRAME_LAST = 10'd6;
    localparam logic [LEN_W-1:0] CRC_BYTES  = 10'd2;
    localparam logic [LEN_W-1:0] R2_BYTES   = 10'd1;
    localparam logic [LEN_W-1:0] R3_BYTES   = 10'd4;

    // Input word, last declared field in the lowest bits.
    typedef struct packed {
        logic [4:0]        pad;
        logic [BYTE_W-1:0] tx_data;
        logic [BYTE_W-1:0] rx_byte;
        logic [LEN_W-1:0]  data_len;
        logic [KIND_W-1:0] transfer_kind;
        logic [ARG_W-1:0]  cmd_arg;
        logic [CMD_W-1:0]  cmd_index;
    } in_data_t;

    // Output word, last declared field in the lowest bits.
    typedef struct packed {
        logic [1:0]          pad;
        logic [STATUS_W-1:0] status;
        logic [ARG_W-1:0]    response_value;
        logic [BYTE_W-1:0]   response_code;
        logic                success;
        logic                next_wants_data;
        logic [BYTE_W-1:0]   data_byte;
        logic                chip_select;
        logic [BYTE_W-1:0]   tx_byte;
    } out_data_t;

    // One complete result word with its side-band bits.
    typedef struct packed {
        logic      done_res;
        logic      data_valid;
        out_data_t data;
    } result_t;

    // Byte of the command frame at the given position.
    function automatic logic [BYTE_W-1:0] cmd_byte(
        input logic [2:0]       idx,
        input logic [CMD_W-1:0] cmd,
        input logic [ARG_W-1:0] arg
    );
        logic [BYTE_W-1:0] b;
        case (idx)
            3'd0:    b = {2'b01, cmd};
            3'd1:    b = arg[31:24];
            3'd2:    b = arg[23:16];
            3'd3:    b = arg[15:8];
            3'd4:    b = arg[7:0];
            3'd5:    b = (cmd == CMD_IF_COND) ? CRC_CMD8 : CRC_OTHER;
            default: b = BYTE_IDLE;
        endcase
        return b;
    endfunction

endpackage

### sv/sd_spi_command_engine.sv
// SD card SPI-mode command engine, one stream word per SPI byte exchange.
// Input words (s_t*) carry either a start (s_tuser low) that latches the
// command, argument, transfer kind and length, or an exchange (s_tuser
// high) that reports the byte the card returned in the previous exchange
// together with an optional write payload byte.
// Every input word produces exactly one output word (m_t*): the next byte
// to drive, chip select, a captured read byte (m_tuser high), a request for
// write data in the next exchange, and on the last word of a command
// (m_tlast high) the status, success flag and response values.
// Each result is registered before it reaches m_tvalid; one word is taken every
// cycle while s_tready is high, limited by the single register stage behind the sequencing logic.
// A two-entry output buffer (result register plus skid register) lets the
// block take one further word while a result waits; when both are full,
// s_tready drops until the receiver takes a word.
// Reset clears the buffers, returns the sequencer to idle and loads the
// default retry limits; configuration writes through the APB port are
// meant for idle periods only.
module sd_spi_command_engine #(
    parameter int MAX_BLOCK_LEN = sdspi_pkg::MAX_BLOCK_LEN_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Input stream.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // cmd_index, cmd_arg, transfer_kind, data_len, rx_byte, tx_data, zero pad
    input  logic [sdspi_pkg::IN_DATA_W-1:0]  s_tdata,
    // operation
    input  logic                             s_tuser,
    // Output stream.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // tx_byte, chip_select, data_byte, next_wants_data, success,
    // response_code, response_value, status, zero pad
    output logic [sdspi_pkg::OUT_DATA_W-1:0] m_tdata,
    // data_valid
    output logic                             m_tuser,
    // done_res
    output logic                             m_tlast,
    // Configuration port.
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sdspi_pkg::PADDR_W-1:0]    paddr,
    input  logic [sdspi_pkg::PDATA_W-1:0]    pwdata,
    output logic [sdspi_pkg::PDATA_W-1:0]    prdata,
    output logic                             pready
);

    localparam int LEN_W   = sdspi_pkg::LEN_W;
    localparam int LEN_MAX = (1 << LEN_W) - 1;
    localparam int LEN_CAP = (MAX_BLOCK_LEN < LEN_MAX) ? MAX_BLOCK_LEN : LEN_MAX;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_READY,
        PH_SEND,
        PH_RESP,
        PH_TRAIL,
        PH_TOKEN,
        PH_RDATA,
        PH_RCRC,
        PH_WDATA,
        PH_WCRC
    } phase_t;

    // Configuration registers.
    logic                                  block_addr_reg;
    logic [sdspi_pkg::RETRY_W-1:0]         ready_lim_reg;
    logic [sdspi_pkg::BYTE_W-1:0]          resp_lim_reg;
    logic [sdspi_pkg::RETRY_W-1:0]         start_lim_reg;
    logic                                  cfg_wr;

    // Sequencer state.
    phase_t                                phase_reg, phase_next;
    logic [sdspi_pkg::RETRY_W-1:0]         retry_reg, retry_next;
    logic [LEN_W-1:0]                      count_reg, count_next;
    logic [sdspi_pkg::CMD_W-1:0]           cmd_reg, cmd_next;
    logic [sdspi_pkg::ARG_W-1:0]           arg_reg, arg_next;
    logic [sdspi_pkg::KIND_W-1:0]          kind_reg, kind_next;
    logic [LEN_W-1:0]                      len_reg, len_next;
    logic [sdspi_pkg::BYTE_W-1:0]          r1_reg, r1_next;
    logic [sdspi_pkg::ARG_W-1:0]           trail_reg, trail_next;

    // Output buffering.
    logic                                  out_valid_reg, out_valid_next;
    sdspi_pkg::result_t                    out_data_reg, out_data_next;
    logic                                  skid_valid_reg, skid_valid_next;
    sdspi_pkg::result_t                    skid_data_reg, skid_data_next;

    sdspi_pkg::in_data_t                   in_word;
    sdspi_pkg::result_t                    res;
    logic                                  accept;
    logic                                  out_take;
    logic [sdspi_pkg::RETRY_W-1:0]         retry_inc;
    logic [LEN_W-1:0]                      count_inc;
    logic [sdspi_pkg::KIND_W-1:0]          start_kind;
    logic [LEN_W-1:0]                      start_len;
    logic                                  r1_err;

    // Result word that ends a command.
    function automatic sdspi_pkg::result_t done_word(
        input logic [sdspi_pkg::STATUS_W-1:0] st,
        input logic [sdspi_pkg::BYTE_W-1:0]   code,
        input logic [sdspi_pkg::ARG_W-1:0]    value
    );
        sdspi_pkg::result_t w;
        w                     = '0;
        w.done_res            = 1'b1;
        w.data.tx_byte        = sdspi_pkg::BYTE_IDLE;
        w.data.success        = (st == sdspi_pkg::ST_OK);
        w.data.response_code  = code;
        w.data.response_value = value;
        w.data.status         = st;
        return w;
    endfunction

    assign in_word   = sdspi_pkg::in_data_t'(s_tdata);
    assign s_tready  = !skid_valid_reg;
    assign accept    = s_tvalid && s_tready;
    assign out_take  = out_valid_reg && m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg.data;
    assign m_tuser   = out_data_reg.data_valid;
    assign m_tlast   = out_data_reg.done_res;
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;

    // Register read-back.
    always_comb
    begin
        case (paddr[3:2])
            sdspi_pkg::REG_BLOCK_ADDR: prdata = {31'd0, block_addr_reg};
            sdspi_pkg::REG_READY_LIM:  prdata = {16'd0, ready_lim_reg};
            sdspi_pkg::REG_RESP_LIM:   prdata = {24'd0, resp_lim_reg};
            sdspi_pkg::REG_START_LIM:  prdata = {16'd0, start_lim_reg};
            default:                   prdata = '0;
        endcase
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_addr_reg <= sdspi_pkg::BLOCK_ADDR_RST;
            ready_lim_reg  <= sdspi_pkg::READY_LIM_RST;
            resp_lim_reg   <= sdspi_pkg::RESP_LIM_RST;
            start_lim_reg  <= sdspi_pkg::START_LIM_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                sdspi_pkg::REG_BLOCK_ADDR: block_addr_reg <= pwdata[0];
                sdspi_pkg::REG_READY_LIM:  ready_lim_reg  <= pwdata[15:0];
                sdspi_pkg::REG_RESP_LIM:   resp_lim_reg   <= pwdata[7:0];
                sdspi_pkg::REG_START_LIM:  start_lim_reg  <= pwdata[15:0];
                default:                   block_addr_reg <= block_addr_reg;
            endcase
        end
    end

    // Start word: kind and length normalisation.
    always_comb
    begin
        start_kind = (in_word.transfer_kind > sdspi_pkg::KIND_WRITE) ?
                     sdspi_pkg::KIND_R1 : in_word.transfer_kind;
        start_len  = (in_word.data_len == '0) ? LEN_W'(1) : in_word.data_len;
        if (start_len > LEN_W'(LEN_CAP))
        begin
            start_len = LEN_W'(LEN_CAP);
        end
    end

    assign retry_inc = retry_reg + 16'd1;
    assign count_inc = count_reg + 10'd1;
    assign r1_err    = (r1_reg[7:1] != '0);

    // Command sequencer: next state and result word for one input word.
    always_comb
    begin
        phase_next  = phase_reg;
        retry_next  = retry_reg;
        count_next  = count_reg;
        cmd_next    = cmd_reg;
        arg_next    = arg_reg;
        kind_next   = kind_reg;
        len_next    = len_reg;
        r1_next     = r1_reg;
        trail_next  = trail_reg;
        res                  = '0;
        res.data.tx_byte     = sdspi_pkg::BYTE_IDLE;
        res.data.chip_select = 1'b1;

        if (s_tuser == sdspi_pkg::OP_START)
        begin
            cmd_next   = in_word.cmd_index;
            kind_next  = start_kind;
            len_next   = start_len;
            arg_next   = in_word.cmd_arg;
            if (block_addr_reg && (start_kind == sdspi_pkg::KIND_READ ||
                                   start_kind == sdspi_pkg::KIND_WRITE))
            begin
                arg_next = {9'd0, in_word.cmd_arg[31:9]};
            end
            retry_next = '0;
            count_next = '0;
            r1_next    = '0;
            trail_next = '0;
            phase_next = PH_READY;
        end
        else
        begin
            case (phase_reg)
                // Poll until the card drives the ready byte.
                PH_READY:
                begin
                    retry_next = retry_inc;
                    if (in_word.rx_byte == sdspi_pkg::BYTE_IDLE)
                    begin
                        phase_next       = PH_SEND;
                        count_next       = '0;
                        res.data.tx_byte = sdspi_pkg::cmd_byte(3'd0, cmd_reg, arg_reg);
                    end
                    else if (retry_inc >= ready_lim_reg)
                    begin
                        phase_next = PH_IDLE;
                        res = done_word(sdspi_pkg::ST_READY_TMO,
                                        sdspi_pkg::BYTE_TIMEOUT, '0);
                    end
                end
                // Command frame, CRC and one trailing idle byte.
                PH_SEND:
                begin
                    if (count_reg < sdspi_pkg::FRAME_LAST)
                    begin
                        count_next       = count_inc;
                        res.data.tx_byte = sdspi_pkg::cmd_byte(count_inc[2:0],
                                                               cmd_reg, arg_reg);
                    end
                    else
                    begin
                        phase_next = PH_RESP;
                        retry_next = '0;
                    end
                end
                // Poll for the R1 byte.
                PH_RESP:
                begin
                    retry_next = retry_inc;
                    if (!in_word.rx_byte[7])
                    begin
                        r1_next    = in_word.rx_byte;
                        count_next = '0;
                        trail_next = '0;
                        if (kind_reg == sdspi_pkg::KIND_R2 ||
                            kind_reg == sdspi_pkg::KIND_R3)
                        begin
                            phase_next = PH_TRAIL;
                        end
                        else if (in_word.rx_byte[7:1] != '0)
                        begin
                            phase_next = PH_IDLE;
                            res = done_word(sdspi_pkg::ST_R1_ERROR, in_word.rx_byte, '0);
                        end
                        else if (kind_reg == sdspi_pkg::KIND_READ)
                        begin
                            phase_next = PH_TOKEN;
                            retry_next = '0;
                        end
                        else if (kind_reg == sdspi_pkg::KIND_WRITE)
                        begin
                            phase_next               = PH_WDATA;
                            res.data.tx_byte         = sdspi_pkg::BYTE_TOKEN;
                            res.data.next_wants_data = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            res = done_word(sdspi_pkg::ST_OK, in_word.rx_byte, '0);
                        end
                    end
                    else if (retry_inc >= {8'd0, resp_lim_reg})
                    begin
                        phase_next = PH_IDLE;
                        res = done_word(sdspi_pkg::ST_RESP_TMO,
                                        sdspi_pkg::BYTE_TIMEOUT, '0);
                    end
                end
                // R2 and R3 trailing bytes, most significant first.
                PH_TRAIL:
                begin
                    trail_next = {trail_reg[23:0], in_word.rx_byte};
                    count_next = count_inc;
                    if (count_inc >= ((kind_reg == sdspi_pkg::KIND_R2) ?
                                      sdspi_pkg::R2_BYTES : sdspi_pkg::R3_BYTES))
                    begin
                        phase_next = PH_IDLE;
                        res = done_word(r1_err ? sdspi_pkg::ST_R1_ERROR : sdspi_pkg::ST_OK,
                                        r1_reg, trail_next);
                    end
                end
                // Wait for the read start token or an error token.
                PH_TOKEN:
                begin
                    retry_next = retry_inc;
                    if (in_word.rx_byte == sdspi_pkg::BYTE_TOKEN)
                    begin
                        phase_next = PH_RDATA;
                        count_next = '0;
                    end
                    else if ((in_word.rx_byte & sdspi_pkg::ERR_TOKEN_MASK) == '0)
                    begin
                        phase_next = PH_IDLE;
                        res = done_word(sdspi_pkg::ST_DATA_ERROR, r1_reg, '0);
                    end
                    else if (retry_inc >= start_lim_reg)
                    begin
                        phase_next = PH_IDLE;
                        res = done_word(sdspi_pkg::ST_START_TMO, r1_reg, '0);
                    end
                end
                // Read payload capture.
                PH_RDATA:
                begin
                    res.data.data_byte = in_word.rx_byte;
                    res.data_valid     = 1'b1;
                    count_next         = count_inc;
                    if (count_inc >= len_reg)
                    begin
                        phase_next = PH_RCRC;
                        count_next = '0;
                    end
                end
                // Read CRC bytes are clocked through and dropped.
                PH_RCRC:
                begin
                    count_next = count_inc;
                    if (count_inc >= sdspi_pkg::CRC_BYTES)
                    begin
                        phase_next = PH_IDLE;
                        res = done_word(sdspi_pkg::ST_OK, r1_reg, '0);
                    end
                end
                // Write payload.
                PH_WDATA:
                begin
                    if (count_reg < len_reg)
                    begin
                        count_next               = count_inc;
                        res.data.tx_byte         = in_word.tx_data;
                        res.data.next_wants_data = (count_inc < len_reg);
                    end
                    else
                    begin
                        phase_next = PH_WCRC;
                        count_next = '0;
                    end
                end
                // Dummy CRC, then the data response check.
                PH_WCRC:
                begin
                    if (count_reg < sdspi_pkg::CRC_BYTES)
                    begin
                        count_next = count_inc;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        res = done_word((in_word.rx_byte[4:0] == sdspi_pkg::DRESP_ACCEPTED) ?
                                        sdspi_pkg::ST_OK : sdspi_pkg::ST_WRITE_REJECT,
                                        r1_reg, '0);
                    end
                end
                default:
                begin
                    phase_next           = PH_IDLE;
                    res.data.chip_select = 1'b0;
                end
            endcase
        end
    end

    // Output register and skid register.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_valid_next = 1'b1;
                out_data_next  = res;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = res;
            end
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    // State and buffer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            retry_reg      <= '0;
            count_reg      <= '0;
            cmd_reg        <= '0;
            arg_reg        <= '0;
            kind_reg       <= '0;
            len_reg        <= '0;
            r1_reg         <= '0;
            trail_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                retry_reg <= retry_next;
                count_reg <= count_next;
                cmd_reg   <= cmd_next;
                arg_reg   <= arg_next;
                kind_reg  <= kind_next;
                len_reg   <= len_next;
                r1_reg    <= r1_next;
                trail_reg <= trail_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    // The skid register only fills behind a waiting result.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a word while the output is empty");

    // A start word always enters the ready poll.
    a_start_to_ready: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_tuser == sdspi_pkg::OP_START |=> phase_reg == PH_READY)
        else $error("start word did not enter the ready poll");

    // The command frame counter never runs past the frame.
    a_send_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_SEND |-> count_reg <= sdspi_pkg::FRAME_LAST)
        else $error("command frame counter out of range");

    // A stalled result word is held until taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |=> out_valid_reg && $stable(out_data_reg))
        else $error("stalled result word changed");

endmodule

### bench/sd_cmd_checker.sv
// Watches both streams and the register port of the SD command engine.
// Every accepted input word is run through a cycle-free copy of the command
// sequencer, and the word it should produce is queued. Output words are then
// compared, field by field, against the oldest queued word.
module sd_cmd_checker
    import sdspi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  m_tuser,
    input  logic                  m_tlast,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    input  logic                  pready,
    output int                    mismatch_count,
    output int                    replies_left
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_READY,
        SEQ_FRAME,
        SEQ_R1,
        SEQ_TRAIL,
        SEQ_TOKEN,
        SEQ_RDATA,
        SEQ_RCRC,
        SEQ_WDATA,
        SEQ_WCRC
    } seq_phase_e;

    // Sequencer state.
    seq_phase_e         seq;
    logic [RETRY_W-1:0] polls;
    logic [LEN_W-1:0]   nbytes;
    logic [CMD_W-1:0]   cmd_q;
    logic [ARG_W-1:0]   arg_q;
    logic [KIND_W-1:0]  kind_q;
    logic [LEN_W-1:0]   len_q;
    logic [BYTE_W-1:0]  r1_q;
    logic [ARG_W-1:0]   trail_q;

    // Register copies, followed from the write traffic on the register port.
    logic               addr_blocks;
    logic [RETRY_W-1:0] ready_lim;
    logic [BYTE_W-1:0]  resp_lim;
    logic [RETRY_W-1:0] start_lim;

    result_t replies_due[$];
    int      fail_tally = 0;

    // A word that drives a byte with the card selected and nothing else set.
    function automatic result_t bus_word(input logic [BYTE_W-1:0] tx);
        result_t r;
        r = '0;
        r.data.tx_byte = tx;
        r.data.chip_select = 1'b1;
        return r;
    endfunction

    // Byte of the command frame at a given position.
    function automatic logic [BYTE_W-1:0] frame_byte(input logic [LEN_W-1:0] pos);
        logic [BYTE_W-1:0] b;
        case (pos)
            10'd0:   b = 8'h40 | {2'b00, cmd_q};
            10'd1:   b = arg_q[31:24];
            10'd2:   b = arg_q[23:16];
            10'd3:   b = arg_q[15:8];
            10'd4:   b = arg_q[7:0];
            10'd5:   b = (cmd_q == CMD_IF_COND) ? CRC_CMD8 : CRC_OTHER;
            default: b = BYTE_IDLE;
        endcase
        return b;
    endfunction

    // Last word of a command: card deselected, completion fields filled in.
    task automatic conclude(
        input  logic [STATUS_W-1:0] st,
        input  logic [BYTE_W-1:0]   code,
        input  logic [ARG_W-1:0]    value,
        output result_t             r
    );
        r = '0;
        r.data.tx_byte = BYTE_IDLE;
        r.done_res = 1'b1;
        r.data.success = (st == ST_OK);
        r.data.response_code = code;
        r.data.response_value = value;
        r.data.status = st;
        seq = SEQ_IDLE;
    endtask

    // Advances the sequencer by one input word and gives the word it answers with.
    task automatic step_engine(input logic op, input in_data_t w, output result_t r);
        logic [LEN_W-1:0]  len;
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] rx;
        rx = w.rx_byte;
        if (op == OP_START)
        begin
            kind = (w.transfer_kind > KIND_WRITE) ? KIND_R1 : w.transfer_kind;
            len = w.data_len;
            if (len == '0)
                len = 10'd1;
            if (len > MAX_BLOCK_LEN_DEF)
                len = LEN_W'(MAX_BLOCK_LEN_DEF);
            cmd_q = w.cmd_index;
            arg_q = w.cmd_arg;
            if (addr_blocks && (kind == KIND_READ || kind == KIND_WRITE))
                arg_q = arg_q >> 9;
            kind_q = kind;
            len_q = len;
            polls = '0;
            nbytes = '0;
            r1_q = '0;
            trail_q = '0;
            seq = SEQ_READY;
            r = bus_word(BYTE_IDLE);
        end
        else
        begin
            case (seq)
                SEQ_READY:
                begin
                    polls = polls + 1'b1;
                    if (rx == BYTE_IDLE)
                    begin
                        seq = SEQ_FRAME;
                        nbytes = '0;
                        r = bus_word(frame_byte(10'd0));
                    end
                    else if (polls >= ready_lim)
                        conclude(ST_READY_TMO, BYTE_TIMEOUT, '0, r);
                    else
                        r = bus_word(BYTE_IDLE);
                end
                SEQ_FRAME:
                begin
                    if (nbytes < FRAME_LAST)
                    begin
                        nbytes = nbytes + 1'b1;
                        r = bus_word(frame_byte(nbytes));
                    end
                    else
                    begin
                        seq = SEQ_R1;
                        polls = '0;
                        r = bus_word(BYTE_IDLE);
                    end
                end
                SEQ_R1:
                begin
                    polls = polls + 1'b1;
                    if (!rx[7])
                    begin
                        r1_q = rx;
                        nbytes = '0;
                        trail_q = '0;
                        if (kind_q == KIND_R2 || kind_q == KIND_R3)
                        begin
                            seq = SEQ_TRAIL;
                            r = bus_word(BYTE_IDLE);
                        end
                        else if (rx[7:1] != '0)
                            conclude(ST_R1_ERROR, r1_q, '0, r);
                        else if (kind_q == KIND_READ)
                        begin
                            seq = SEQ_TOKEN;
                            polls = '0;
                            r = bus_word(BYTE_IDLE);
                        end
                        else if (kind_q == KIND_WRITE)
                        begin
                            seq = SEQ_WDATA;
                            r = bus_word(BYTE_TOKEN);
                            r.data.next_wants_data = 1'b1;
                        end
                        else
                            conclude(ST_OK, r1_q, '0, r);
                    end
                    else if (polls >= {8'd0, resp_lim})
                        conclude(ST_RESP_TMO, BYTE_TIMEOUT, '0, r);
                    else
                        r = bus_word(BYTE_IDLE);
                end
                SEQ_TRAIL:
                begin
                    trail_q = {trail_q[23:0], rx};
                    nbytes = nbytes + 1'b1;
                    if (nbytes >= ((kind_q == KIND_R2) ? R2_BYTES : R3_BYTES))
                        conclude((r1_q[7:1] != '0) ? ST_R1_ERROR : ST_OK, r1_q, trail_q, r);
                    else
                        r = bus_word(BYTE_IDLE);
                end
                SEQ_TOKEN:
                begin
                    polls = polls + 1'b1;
                    if (rx == BYTE_TOKEN)
                    begin
                        seq = SEQ_RDATA;
                        nbytes = '0;
                        r = bus_word(BYTE_IDLE);
                    end
                    else if ((rx & ERR_TOKEN_MASK) == '0)
                        conclude(ST_DATA_ERROR, r1_q, '0, r);
                    else if (polls >= start_lim)
                        conclude(ST_START_TMO, r1_q, '0, r);
                    else
                        r = bus_word(BYTE_IDLE);
                end
                SEQ_RDATA:
                begin
                    r = bus_word(BYTE_IDLE);
                    r.data.data_byte = rx;
                    r.data_valid = 1'b1;
                    nbytes = nbytes + 1'b1;
                    if (nbytes >= len_q)
                    begin
                        seq = SEQ_RCRC;
                        nbytes = '0;
                    end
                end
                SEQ_RCRC:
                begin
                    nbytes = nbytes + 1'b1;
                    if (nbytes >= CRC_BYTES)
                        conclude(ST_OK, r1_q, '0, r);
                    else
                        r = bus_word(BYTE_IDLE);
                end
                SEQ_WDATA:
                begin
                    if (nbytes < len_q)
                    begin
                        nbytes = nbytes + 1'b1;
                        r = bus_word(w.tx_data);
                        r.data.next_wants_data = (nbytes < len_q);
                    end
                    else
                    begin
                        seq = SEQ_WCRC;
                        nbytes = '0;
                        r = bus_word(BYTE_IDLE);
                    end
                end
                SEQ_WCRC:
                begin
                    if (nbytes < CRC_BYTES)
                    begin
                        nbytes = nbytes + 1'b1;
                        r = bus_word(BYTE_IDLE);
                    end
                    else if (rx[4:0] == DRESP_ACCEPTED)
                        conclude(ST_OK, r1_q, '0, r);
                    else
                        conclude(ST_WRITE_REJECT, r1_q, '0, r);
                end
                default:
                begin
                    // An exchange with no command running is answered but ignored.
                    seq = SEQ_IDLE;
                    r = '0;
                    r.data.tx_byte = BYTE_IDLE;
                end
            endcase
        end
    endtask

    function automatic int field_differs(
        input string       name,
        input logic [31:0] want,
        input logic [31:0] got
    );
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Register writes, input words and output words, all seen at the clock edge.
    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t   fresh;
        result_t   due;
        out_data_t seen;
        int        bad;
        if (!rst_n)
        begin
            seq = SEQ_IDLE;
            polls = '0;
            nbytes = '0;
            cmd_q = '0;
            arg_q = '0;
            kind_q = '0;
            len_q = '0;
            r1_q = '0;
            trail_q = '0;
            addr_blocks = BLOCK_ADDR_RST;
            ready_lim = READY_LIM_RST;
            resp_lim = RESP_LIM_RST;
            start_lim = START_LIM_RST;
            replies_due.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_BLOCK_ADDR: addr_blocks = pwdata[0];
                    REG_READY_LIM:  ready_lim = pwdata[15:0];
                    REG_RESP_LIM:   resp_lim = pwdata[7:0];
                    REG_START_LIM:  start_lim = pwdata[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                step_engine(s_tuser, in_data_t'(s_tdata), fresh);
                replies_due.push_back(fresh);
            end
            if (m_tvalid && m_tready)
            begin
                if (replies_due.size() == 0)
                begin
                    $error("output word arrived with none outstanding");
                    fail_tally++;
                end
                else
                begin
                    due = replies_due.pop_front();
                    seen = out_data_t'(m_tdata);
                    bad = 0;
                    bad += field_differs("tx_byte", 32'(due.data.tx_byte), 32'(seen.tx_byte));
                    bad += field_differs("chip_select", 32'(due.data.chip_select),
                                         32'(seen.chip_select));
                    bad += field_differs("data_byte", 32'(due.data.data_byte),
                                         32'(seen.data_byte));
                    bad += field_differs("data_valid", 32'(due.data_valid), 32'(m_tuser));
                    bad += field_differs("next_wants_data", 32'(due.data.next_wants_data),
                                         32'(seen.next_wants_data));
                    bad += field_differs("done_res", 32'(due.done_res), 32'(m_tlast));
                    bad += field_differs("success", 32'(due.data.success), 32'(seen.success));
                    bad += field_differs("response_code", 32'(due.data.response_code),
                                         32'(seen.response_code));
                    bad += field_differs("response_value", due.data.response_value,
                                         seen.response_value);
                    bad += field_differs("status", 32'(due.data.status), 32'(seen.status));
                    if (bad != 0)
                        fail_tally++;
                end
            end
        end
        mismatch_count <= fail_tally;
        replies_left <= replies_due.size();
    end

endmodule

### bench/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import sdspi_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_WORDS    = 85;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [PADDR_W-1:0]    paddr = '0;
    logic [PDATA_W-1:0]    pwdata = '0;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    int mismatch_count;
    int replies_left;

    // Pacing of both sides and the one long hold-off on the output.
    int   send_gap_pct = 0;
    int   stall_pct = 0;
    logic hold_request = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;
    int   quiet_cycles = 0;

    // Effective retry limits, a written zero counting as one poll.
    int   ready_eff = 10000;
    int   resp_eff = 100;
    int   start_eff = 2500;
    int   words_sent = 0;
    int   cut_left = -1;
    logic big_next = 1'b0;

    sd_spi_command_engine u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    sd_cmd_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .mismatch_count (mismatch_count),
        .replies_left   (replies_left)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Output side: random stalls, and once a long hold-off so the block backs up.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_request && !hold_done)
        begin
            m_tready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Ends the run if neither stream moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offers one word, after a random gap, and waits until it is taken.
    task automatic put_word(input logic op, input in_data_t w);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= w;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic start_cmd(
        input logic [CMD_W-1:0]  cmd,
        input logic [ARG_W-1:0]  arg,
        input logic [KIND_W-1:0] kind,
        input logic [LEN_W-1:0]  len
    );
        in_data_t w;
        w = '0;
        w.cmd_index = cmd;
        w.cmd_arg = arg;
        w.transfer_kind = kind;
        w.data_len = len;
        w.rx_byte = 8'($urandom);
        w.tx_data = 8'($urandom);
        put_word(OP_START, w);
    endtask

    // One byte exchange; the fields an exchange ignores carry random values.
    // A command cut short stops sending here, so the next start abandons it.
    task automatic exchange(input logic [BYTE_W-1:0] rx);
        in_data_t    w;
        logic [95:0] junk;
        if (cut_left == 0)
            return;
        if (cut_left > 0)
            cut_left--;
        junk = {$urandom, $urandom, $urandom};
        w = junk[71:0];
        w.pad = '0;
        w.rx_byte = rx;
        put_word(OP_EXCHANGE, w);
    endtask

    // Waits until every output word has been taken.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (replies_left != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
    endtask

    task automatic set_config(input int ba, input int rdy, input int rsp, input int strt);
        drain();
        write_reg(REG_BLOCK_ADDR, 32'(ba));
        write_reg(REG_READY_LIM, 32'(rdy));
        write_reg(REG_RESP_LIM, 32'(rsp));
        write_reg(REG_START_LIM, 32'(strt));
        psel <= 1'b0;
        penable <= 1'b0;
        ready_eff = (rdy == 0) ? 1 : rdy;
        resp_eff = (rsp == 0) ? 1 : rsp;
        start_eff = (strt == 0) ? 1 : strt;
    endtask

    // One command with a plausible card on the other side, or a burst of noise.
    // Faults: busy timeout, response timeout, R1 error, start token timeout,
    // data error token, rejected write, and a command abandoned part way.
    task automatic random_command();
        int                n;
        int                fault;
        int                sel;
        logic [KIND_W-1:0] kind;
        logic [KIND_W-1:0] eff;
        logic [LEN_W-1:0]  len;
        logic [LEN_W-1:0]  eff_len;
        logic [BYTE_W-1:0] r1;
        logic [BYTE_W-1:0] b;
        logic [95:0]       junk;
        in_data_t          w;
        if (!big_next && $urandom_range(0, 99) < 6)
        begin
            repeat ($urandom_range(1, 3))
            begin
                junk = {$urandom, $urandom, $urandom};
                w = junk[71:0];
                w.pad = '0;
                put_word(1'($urandom_range(0, 1)), w);
            end
            return;
        end
        sel = $urandom_range(0, 8);
        if (sel < 5)
            kind = 3'(sel);
        else if (sel == 8)
            kind = 3'($urandom_range(5, 7));
        else
            kind = 3'($urandom_range(3, 4));
        if ($urandom_range(0, 9) == 0)
            len = 10'($urandom_range(13, 48));
        else
            len = 10'($urandom_range(0, 12));
        fault = $urandom_range(0, 99);
        if (big_next)
        begin
            kind = KIND_READ;
            len = 10'h3FF;
            fault = 50;
            big_next = 1'b0;
        end
        eff = (kind > KIND_WRITE) ? KIND_R1 : kind;
        eff_len = (len == '0) ? 10'd1 : ((len > MAX_BLOCK_LEN_DEF) ? 10'd512 : len);
        cut_left = (fault >= 90) ? $urandom_range(0, 12) : -1;
        start_cmd(($urandom_range(0, 4) == 0) ? CMD_IF_COND : 6'($urandom_range(0, 63)),
                  $urandom, kind, len);

        // Card busy, then ready.
        n = $urandom_range(0, 3);
        if (n > ready_eff - 1)
            n = ready_eff - 1;
        if (fault < 5 && ready_eff <= 40)
            n = ready_eff;
        repeat (n) exchange(8'($urandom_range(0, 254)));
        if (n == ready_eff)
            return;
        exchange(BYTE_IDLE);
        repeat (7) exchange(8'($urandom));

        // Response polling and the R1 byte.
        n = $urandom_range(0, 3);
        if (n > resp_eff - 1)
            n = resp_eff - 1;
        if (fault >= 5 && fault < 10 && resp_eff <= 40)
            n = resp_eff;
        repeat (n) exchange(8'($urandom_range(128, 255)));
        if (n == resp_eff)
            return;
        if (fault >= 10 && fault < 18)
            r1 = 8'($urandom_range(2, 127));
        else
            r1 = 8'($urandom_range(0, 1));
        exchange(r1);
        if (eff == KIND_R2 || eff == KIND_R3)
        begin
            repeat ((eff == KIND_R2) ? 1 : 4) exchange(8'($urandom));
            return;
        end
        if (r1 > 8'd1 || eff == KIND_R1)
            return;

        if (eff == KIND_READ)
        begin
            n = $urandom_range(0, 3);
            if (n > start_eff - 1)
                n = start_eff - 1;
            if (fault >= 18 && fault < 23 && start_eff <= 40)
                n = start_eff;
            repeat (n)
            begin
                b = 8'($urandom_range(32, 255));
                exchange((b == BYTE_TOKEN) ? BYTE_IDLE : b);
            end
            if (n == start_eff)
                return;
            if (fault >= 23 && fault < 28)
            begin
                exchange(8'($urandom_range(0, 31)));
                return;
            end
            exchange(BYTE_TOKEN);
            repeat (eff_len) exchange(8'($urandom));
            repeat (2) exchange(8'($urandom));
        end
        else
        begin
            // Payload, the turnaround word, two CRC bytes, then the data response.
            repeat (eff_len + 1) exchange(8'($urandom));
            repeat (2) exchange(8'($urandom));
            b = 8'($urandom);
            if (fault >= 28 && fault < 38)
            begin
                if (b[4:0] == DRESP_ACCEPTED)
                    b[1] = ~b[1];
            end
            else
                b[4:0] = DRESP_ACCEPTED;
            exchange(b);
        end
    endtask

    initial
    begin
        int target;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: an exchange while idle, a start that abandons another,
        // command 8 with an out-of-range kind and length, and an R3 whose R1
        // byte carries errors.
        exchange(8'hA5);
        start_cmd(6'd63, 32'hFFFF_FFFF, KIND_READ, 10'd0);
        start_cmd(CMD_IF_COND, 32'h0000_01AA, 3'd7, 10'h3FF);
        exchange(8'h00);
        exchange(BYTE_IDLE);
        repeat (7) exchange(8'($urandom));
        exchange(8'hFF);
        exchange(8'h01);
        start_cmd(6'd58, 32'h0000_0000, KIND_R3, 10'd1);
        exchange(BYTE_IDLE);
        repeat (7) exchange(8'($urandom));
        exchange(8'h05);
        exchange(8'hFF);
        exchange(8'h00);
        exchange(8'hAA);
        exchange(8'h55);

        // Random commands over several register settings and pacing modes.
        for (int p = 0; p < 7; p++)
        begin
            case (p)
                1: set_config(1, 1, 1, 1);
                2: set_config(0, 0, 0, 0);
                3: set_config(1, 65535, 255, 65535);
                4: set_config($urandom_range(0, 1), $urandom_range(2, 20),
                              $urandom_range(2, 20), $urandom_range(2, 20));
                5: set_config(0, 10000, 100, 2500);
                6: set_config(1, $urandom_range(1, 6), $urandom_range(1, 6),
                              $urandom_range(1, 6));
                default: ;
            endcase
            case (p % 4)
                0:
                begin
                    send_gap_pct = 0;
                    stall_pct <= 0;
                end
                1:
                begin
                    send_gap_pct = 45;
                    stall_pct <= 0;
                end
                2:
                begin
                    send_gap_pct = 0;
                    stall_pct <= 45;
                end
                default:
                begin
                    send_gap_pct = 10;
                    stall_pct <= 10;
                end
            endcase
            if (p == 0)
                hold_request <= 1'b1;
            if (p == 3)
                big_next = 1'b1;
            target = words_sent + PHASE_WORDS;
            while (words_sent < target)
                random_command();
        end

        drain();
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
